>>> src/prl_pkg.sv
// Shared types, codes and reset values for the password retry lockout block.
// No dependencies; every other file in src imports this package.
package prl_pkg;

    localparam int unsigned CODE_W  = 32;
    localparam int unsigned TRIES_W = 4;
    localparam int unsigned SECS_W  = 16;
    localparam int unsigned TIER_W  = 2;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [CODE_W-1:0]  PASS_CODE_RST   = 32'h3132_3334;
    localparam logic [TRIES_W-1:0] FIRST_TRIES_RST = 4'd5;
    localparam logic [TRIES_W-1:0] LATER_TRIES_RST = 4'd3;
    localparam logic [SECS_W-1:0]  SHORT_SECS_RST  = 16'd30;
    localparam logic [SECS_W-1:0]  MID_SECS_RST    = 16'd120;
    localparam logic [SECS_W-1:0]  LONG_SECS_RST   = 16'd1800;

    localparam logic [TIER_W-1:0] TIER_FIRST  = 2'd0;
    localparam logic [TIER_W-1:0] TIER_SECOND = 2'd1;
    localparam logic [TIER_W-1:0] TIER_THIRD  = 2'd2;

    localparam logic OP_ATTEMPT = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_WRONG   = 3'd0,
        ST_GRANTED = 3'd1,
        ST_LOCKED  = 3'd2,
        ST_REFUSED = 3'd3,
        ST_IDLE    = 3'd4,
        ST_EXPIRED = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PASS_CODE   = 3'd0,
        CFG_FIRST_TRIES = 3'd1,
        CFG_LATER_TRIES = 3'd2,
        CFG_SHORT_SECS  = 3'd3,
        CFG_MID_SECS    = 3'd4,
        CFG_LONG_SECS   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CODE_W-1:0]  pass_code;
        logic [TRIES_W-1:0] first_tries;
        logic [TRIES_W-1:0] later_tries;
        logic [SECS_W-1:0]  short_secs;
        logic [SECS_W-1:0]  mid_secs;
        logic [SECS_W-1:0]  long_secs;
    } t_cfg;

    typedef struct packed {
        logic [TIER_W-1:0]  tier;
        logic [SECS_W-1:0]  seconds_left;
        logic [TRIES_W-1:0] tries_left;
        t_status            status;
    } t_result;

    function automatic logic [TRIES_W-1:0] tries_for_tier(input t_cfg cfg,
                                                          input logic [TIER_W-1:0] tier);
        return (tier == TIER_FIRST) ? cfg.first_tries : cfg.later_tries;
    endfunction

    function automatic logic [SECS_W-1:0] secs_for_tier(input t_cfg cfg,
                                                        input logic [TIER_W-1:0] tier);
        logic [SECS_W-1:0] secs;
        case (tier)
            TIER_FIRST:  secs = cfg.short_secs;
            TIER_SECOND: secs = cfg.mid_secs;
            default:     secs = cfg.long_secs;
        endcase
        return secs;
    endfunction

endpackage

>>> src/prl_cfg_regs.sv
// Configuration register file for the password retry lockout block.
// Depends on prl_pkg for the register index codes and reset values.
module prl_cfg_regs import prl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CODE_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pass_code   <= PASS_CODE_RST;
            r_cfg.first_tries <= FIRST_TRIES_RST;
            r_cfg.later_tries <= LATER_TRIES_RST;
            r_cfg.short_secs  <= SHORT_SECS_RST;
            r_cfg.mid_secs    <= MID_SECS_RST;
            r_cfg.long_secs   <= LONG_SECS_RST;
        end else if (i_cfg_valid) begin
            // Indexes past the last register are accepted and dropped.
            case (t_cfg_idx'(i_cfg_index))
                CFG_PASS_CODE:   r_cfg.pass_code   <= i_cfg_data;
                CFG_FIRST_TRIES: r_cfg.first_tries <= i_cfg_data[TRIES_W-1:0];
                CFG_LATER_TRIES: r_cfg.later_tries <= i_cfg_data[TRIES_W-1:0];
                CFG_SHORT_SECS:  r_cfg.short_secs  <= i_cfg_data[SECS_W-1:0];
                CFG_MID_SECS:    r_cfg.mid_secs    <= i_cfg_data[SECS_W-1:0];
                CFG_LONG_SECS:   r_cfg.long_secs   <= i_cfg_data[SECS_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> src/prl_core.sv
// Lockout state (tier, attempts, lock flag, countdown) and its per-item update.
// Depends on prl_pkg; driven from the input register in the top level.
module prl_core import prl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_step,
    input  logic              i_op,
    input  logic [CODE_W-1:0] i_code,
    output t_result           o_result
);

    logic [TIER_W-1:0]  r_tier,      n_tier;
    logic               r_locked,    n_locked;
    logic [TRIES_W-1:0] r_attempts,  n_attempts;
    logic [SECS_W-1:0]  r_countdown, n_countdown;
    t_status            n_status;
    logic [TRIES_W-1:0] dec_attempts;

    always_comb begin
        n_tier       = r_tier;
        n_locked     = r_locked;
        n_attempts   = r_attempts;
        n_countdown  = r_countdown;
        n_status     = ST_IDLE;
        dec_attempts = (r_attempts == '0) ? '0 : r_attempts - TRIES_W'(1);
        if (i_op == OP_ATTEMPT) begin
            if (r_locked) begin
                n_status = ST_REFUSED;
            end else if (i_code == i_cfg.pass_code) begin
                n_attempts = tries_for_tier(i_cfg, r_tier);
                n_status   = ST_GRANTED;
            end else begin
                n_attempts = dec_attempts;
                if (dec_attempts == '0) begin
                    n_locked    = 1'b1;
                    n_countdown = secs_for_tier(i_cfg, r_tier);
                    n_status    = ST_LOCKED;
                end else begin
                    n_status = ST_WRONG;
                end
            end
        end else if (r_locked) begin
            if (r_countdown <= SECS_W'(1)) begin
                // Expiry escalates the tier, staying at the third; both later tiers refill the same way.
                n_locked    = 1'b0;
                n_countdown = '0;
                n_tier      = (r_tier == TIER_FIRST) ? TIER_SECOND : TIER_THIRD;
                n_attempts  = i_cfg.later_tries;
                n_status    = ST_EXPIRED;
            end else begin
                n_countdown = r_countdown - SECS_W'(1);
            end
        end
    end

    assign o_result.status       = n_status;
    assign o_result.tries_left   = n_attempts;
    assign o_result.seconds_left = n_locked ? n_countdown : '0;
    assign o_result.tier         = n_tier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tier      <= TIER_FIRST;
            r_locked    <= 1'b0;
            r_attempts  <= FIRST_TRIES_RST;
            r_countdown <= '0;
        end else if (i_step) begin
            r_tier      <= n_tier;
            r_locked    <= n_locked;
            r_attempts  <= n_attempts;
            r_countdown <= n_countdown;
        end
    end

`ifndef SYNTHESIS
    a_unlocked_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_locked |-> (r_countdown == '0))
        else $error("countdown nonzero while unlocked");

    a_tier_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tier != 2'd3)
        else $error("tier out of range");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_locked && (i_op == OP_ATTEMPT)) |=>
            (r_locked && $stable(r_attempts) && $stable(r_tier) && $stable(r_countdown)))
        else $error("attempt while locked changed state");

    a_tier_only_rises_on_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_op == OP_ATTEMPT)) |=> $stable(r_tier))
        else $error("tier changed on a code attempt");
`endif

endmodule

>>> src/password_retry_lockout.sv
// Top level of the password retry lockout block: stream ports, input and result registers.
// Depends on prl_pkg, prl_cfg_regs and prl_core.
//
// One result comes out for every input transaction, in order. The block takes one
// transaction per clock cycle when the output side keeps up; an accepted input passes
// through the input register, then the result register, and the state update sits in
// the single combinational path between those two registers. Both registers hold while
// the output is stalled, so at most two items are in flight. Configuration writes are
// always accepted; tries and lock times take effect at the next refill of the attempt
// counter or the next lock, and a new pass code at the next code attempt.
module password_retry_lockout import prl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CODE_W-1:0]     i_cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CODE_W-1:0]     s_axis_tdata,  // [31:0] code
    input  logic                  s_axis_tuser,  // [0] op
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [2:0] status, [6:3] tries_left,
                                                 // [22:7] seconds_left, [24:23] tier
);

    t_cfg              cfg;
    t_result           core_result;
    logic              r_in_valid;
    logic              r_in_op;
    logic [CODE_W-1:0] r_in_code;
    logic              r_out_valid;
    t_result           r_out;
    logic              advance;
    logic              step;

    prl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The result register can load whenever it is empty or being drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    prl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_op     (r_in_op),
        .i_code   (r_in_code),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op   <= s_axis_tuser;
            r_in_code <= s_axis_tdata;
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

`ifndef SYNTHESIS
    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input register lost an item while stalled");

    a_out_loaded_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed item did not reach the result register");

    a_no_load_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && m_axis_tready) |=> !r_out_valid)
        else $error("result appeared without an input item");
`endif

endmodule

>>> verif/tb_password_retry_lockout.sv
// Self-checking testbench for password_retry_lockout: directed tier walks, then random traffic.
// Depends on prl_pkg and the RTL under src; random values come from the simulator seed.
module tb_password_retry_lockout;
    timeunit 1ns;
    timeprecision 1ps;
    import prl_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1700;
    localparam int unsigned MAX_GAP       = 14;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(CFG_LONG_SECS + 1);

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CODE_W-1:0]     i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [CODE_W-1:0]     s_axis_tdata  = '0;  // [31:0] code
    logic                  s_axis_tuser  = 1'b0; // [0] op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [2:0] status, [6:3] tries_left,
                                           // [22:7] seconds_left, [24:23] tier

    // Expected view of the lockout state and its registers.
    t_cfg               lk_regs;
    logic [TIER_W-1:0]  lk_tier;
    logic               lk_locked;
    logic [TRIES_W-1:0] lk_tries;
    logic [SECS_W-1:0]  lk_countdown;

    t_result     pending_results[$];
    int unsigned fail_count = 0;
    bit          idle_on    = 1'b1;
    int unsigned stall_left = 0;

    password_retry_lockout dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void reset_lockout_model();
        lk_regs.pass_code   = PASS_CODE_RST;
        lk_regs.first_tries = FIRST_TRIES_RST;
        lk_regs.later_tries = LATER_TRIES_RST;
        lk_regs.short_secs  = SHORT_SECS_RST;
        lk_regs.mid_secs    = MID_SECS_RST;
        lk_regs.long_secs   = LONG_SECS_RST;
        lk_tier      = TIER_FIRST;
        lk_locked    = 1'b0;
        lk_tries     = FIRST_TRIES_RST;
        lk_countdown = '0;
    endfunction

    function automatic logic [TRIES_W-1:0] refill_count();
        return (lk_tier == TIER_FIRST) ? lk_regs.first_tries : lk_regs.later_tries;
    endfunction

    // Applies one input transaction to the expected state and returns its result.
    function automatic t_result advance_lockout(input logic op, input logic [CODE_W-1:0] code);
        t_result r;
        if (op == OP_ATTEMPT) begin
            if (lk_locked) begin
                r.status = ST_REFUSED;
            end else if (code == lk_regs.pass_code) begin
                lk_tries = refill_count();
                r.status = ST_GRANTED;
            end else begin
                // The counter saturates, so a wrong code at zero locks again.
                if (lk_tries != 0) lk_tries = lk_tries - 1'b1;
                if (lk_tries == 0) begin
                    lk_locked = 1'b1;
                    case (lk_tier)
                        TIER_FIRST:  lk_countdown = lk_regs.short_secs;
                        TIER_SECOND: lk_countdown = lk_regs.mid_secs;
                        default:     lk_countdown = lk_regs.long_secs;
                    endcase
                    r.status = ST_LOCKED;
                end else begin
                    r.status = ST_WRONG;
                end
            end
        end else if (!lk_locked) begin
            r.status = ST_IDLE;
        end else if (lk_countdown <= 1) begin
            lk_locked    = 1'b0;
            lk_countdown = '0;
            lk_tier      = (lk_tier == TIER_FIRST) ? TIER_SECOND : TIER_THIRD;
            lk_tries     = refill_count();
            r.status     = ST_EXPIRED;
        end else begin
            lk_countdown = lk_countdown - 1'b1;
            r.status     = ST_IDLE;
        end
        r.tries_left   = lk_tries;
        r.seconds_left = lk_locked ? lk_countdown : '0;
        r.tier         = lk_tier;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    // Result side: checks each transaction and draws a stall before the next one.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(t_result)-1:0];
            if (pending_results.size() == 0) begin
                fail_count++;
                $error("result 0x%08h arrived with no expectation pending", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.tries_left !== want.tries_left)
                    flag_mismatch("tries_left", 32'(want.tries_left), 32'(got.tries_left));
                if (got.seconds_left !== want.seconds_left)
                    flag_mismatch("seconds_left", 32'(want.seconds_left),
                                  32'(got.seconds_left));
                if (got.tier !== want.tier)
                    flag_mismatch("tier", 32'(want.tier), 32'(got.tier));
                if (m_axis_tdata[OUT_DATA_W-1:$bits(t_result)] !== '0)
                    flag_mismatch("padding", '0,
                                  32'(m_axis_tdata[OUT_DATA_W-1:$bits(t_result)]));
            end
            stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (stall_left != 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (stall_left <= 1) begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
            end else begin
                stall_left--;
            end
        end
    end

    // Valid is only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic op, input logic [CODE_W-1:0] code);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(advance_lockout(op, code));
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PASS_CODE:   lk_regs.pass_code   = value;
            CFG_FIRST_TRIES: lk_regs.first_tries = value[TRIES_W-1:0];
            CFG_LATER_TRIES: lk_regs.later_tries = value[TRIES_W-1:0];
            CFG_SHORT_SECS:  lk_regs.short_secs  = value[SECS_W-1:0];
            CFG_MID_SECS:    lk_regs.mid_secs    = value[SECS_W-1:0];
            CFG_LONG_SECS:   lk_regs.long_secs   = value[SECS_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_tier0_refill_and_lock();
        send_item(OP_ATTEMPT, PASS_CODE_RST);
        send_item(OP_TICK, '1);
        send_item(OP_ATTEMPT, '0);
        send_item(OP_ATTEMPT, '1);
        send_item(OP_ATTEMPT, PASS_CODE_RST ^ 32'h8000_0000);
        send_item(OP_ATTEMPT, PASS_CODE_RST);
        write_reg(CFG_FIRST_TRIES, 32'd15);
        send_item(OP_ATTEMPT, PASS_CODE_RST);
        // A zero refill leaves no attempts; the next wrong code locks at once.
        write_reg(CFG_FIRST_TRIES, 32'd0);
        send_item(OP_ATTEMPT, PASS_CODE_RST);
        send_item(OP_ATTEMPT, 32'h0000_0001);
        send_item(OP_ATTEMPT, PASS_CODE_RST);
        repeat (10) send_item(OP_TICK, $urandom());
        // A new short lock time must not disturb the countdown already running.
        write_reg(CFG_SHORT_SECS, 32'd5);
        repeat (20) send_item(OP_TICK, $urandom());
    endtask

    task automatic test_tier1_zero_lock();
        write_reg(CFG_SHORT_SECS, 32'hFFFF);
        write_reg(CFG_SHORT_SECS, 32'd0);
        write_reg(CFG_MID_SECS, 32'd0);
        repeat (3) send_item(OP_ATTEMPT, $urandom() ^ PASS_CODE_RST | 32'h1);
        send_item(OP_ATTEMPT, PASS_CODE_RST);
        send_item(OP_TICK, $urandom());
    endtask

    task automatic test_tier2_extremes();
        write_reg(CFG_PASS_CODE, '0);
        write_reg(CFG_LATER_TRIES, 32'd0);
        write_reg(CFG_LONG_SECS, 32'd1);
        send_item(OP_ATTEMPT, '0);
        send_item(OP_ATTEMPT, 32'h0000_0001);
        send_item(OP_TICK, $urandom());
        write_reg(CFG_MID_SECS, 32'hFFFF);
        write_reg(CFG_LATER_TRIES, 32'd15);
        write_reg(CFG_PASS_CODE, '1);
        write_reg(CFG_LONG_SECS, 32'd256);
        send_item(OP_ATTEMPT, '1);
        repeat (15) send_item(OP_ATTEMPT, $urandom() & 32'h7FFF_FFFF);
        send_item(OP_ATTEMPT, '1);
        // A long third-tier lock is ridden out at full rate on both sides.
        idle_on = 1'b0;
        repeat (256) send_item(OP_TICK, $urandom());
        idle_on = 1'b1;
    endtask

    task automatic send_random_item();
        logic [CODE_W-1:0] code;
        int unsigned       pick;
        pick = $urandom_range(0, 9);
        code = $urandom();
        if (lk_locked) begin
            if (pick < 2) send_item(OP_ATTEMPT, (pick == 0) ? lk_regs.pass_code : code);
            else send_item(OP_TICK, code);
        end else if (pick < 3) begin
            send_item(OP_ATTEMPT, lk_regs.pass_code);
        end else if (pick < 5) begin
            send_item(OP_ATTEMPT, lk_regs.pass_code ^ (32'h1 << $urandom_range(0, CODE_W-1)));
        end else if (pick < 8) begin
            send_item(OP_ATTEMPT, code);
        end else begin
            send_item(OP_TICK, code);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned phase_len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) != 0) write_reg(CFG_PASS_CODE, $urandom());
            write_reg(CFG_LATER_TRIES, ($urandom_range(0, 7) == 0) ?
                      (($urandom_range(0, 1) != 0) ? 15 : 0) : $urandom_range(1, 6));
            write_reg(CFG_LONG_SECS, ($urandom_range(0, 7) == 0) ?
                      $urandom_range(0, 400) : $urandom_range(0, 12));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_FIRST_TRIES, $urandom());
                write_reg(CFG_SHORT_SECS, $urandom());
                write_reg(CFG_MID_SECS, $urandom());
                write_reg(CFG_IDX_W'(CFG_SPARE_IDX + $urandom_range(0, 1)), $urandom());
            end
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(50, 300);
            repeat (phase_len) begin
                send_random_item();
                sent++;
                if ($urandom_range(0, 99) == 0) wait_drain();
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        reset_lockout_model();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tier0_refill_and_lock();
        test_tier1_zero_lock();
        test_tier2_extremes();
        test_random_traffic();
        wait_drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
